FILE: hw/rtl/tmcs_pkg.sv
// Shared types, constants and the format table for the mip chain size unit.
package tmcs_pkg;

  localparam int DIM_BITS     = 16;
  localparam int LAYER_BITS   = 12;
  localparam int FORMAT_COUNT = 22;

  localparam int CODE_W  = 8;
  localparam int MIP_W   = 5;
  localparam int TOTAL_W = 59;
  localparam int BYTES_W = 5;
  localparam int DL_W    = 2 * LAYER_BITS;
  localparam int BDL_W   = BYTES_W + DL_W;
  // Accumulator for the sum of block counts over all levels, two bits wider than the level zero area
  localparam int ACC_W   = 2 * DIM_BITS + 2;
  localparam int LO_W    = ACC_W / 2;
  localparam int HI_W    = ACC_W - LO_W;

  typedef struct packed {
    logic [BYTES_W-1:0] bytes;
    logic               edge4;
    logic               depth;
  } fmt_info_t;

  // One classified descriptor, as it travels from front to back
  typedef struct packed {
    logic [DIM_BITS-1:0] width;
    logic [DIM_BITS-1:0] height;
    logic [MIP_W-1:0]    mips;
    fmt_info_t           fmt;
    logic                known;
    logic [DL_W-1:0]     dl;
  } tmcs_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Format table; the Unknown entry is code zero
  function automatic fmt_info_t fmt_lookup(input logic [CODE_W-1:0] code);
    fmt_info_t f;
    f = '{bytes: BYTES_W'(0), edge4: 1'b0, depth: 1'b0};
    case (code)
      8'd1:  f.bytes = BYTES_W'(1);
      8'd2:  f.bytes = BYTES_W'(2);
      8'd3:  f.bytes = BYTES_W'(4);
      8'd4:  f.bytes = BYTES_W'(4);
      8'd5:  f.bytes = BYTES_W'(4);
      8'd6:  f.bytes = BYTES_W'(2);
      8'd7:  f.bytes = BYTES_W'(4);
      8'd8:  f.bytes = BYTES_W'(8);
      8'd9:  f.bytes = BYTES_W'(4);
      8'd10: f.bytes = BYTES_W'(8);
      8'd11: f.bytes = BYTES_W'(16);
      8'd12: f.bytes = BYTES_W'(4);
      8'd13: f.bytes = BYTES_W'(4);
      8'd14: f.bytes = BYTES_W'(12);
      8'd15: f = '{bytes: BYTES_W'(2),  edge4: 1'b0, depth: 1'b1};
      8'd16: f = '{bytes: BYTES_W'(4),  edge4: 1'b0, depth: 1'b1};
      8'd17: f = '{bytes: BYTES_W'(4),  edge4: 1'b0, depth: 1'b1};
      8'd18: f = '{bytes: BYTES_W'(8),  edge4: 1'b1, depth: 1'b0};
      8'd19: f = '{bytes: BYTES_W'(16), edge4: 1'b1, depth: 1'b0};
      8'd20: f = '{bytes: BYTES_W'(16), edge4: 1'b1, depth: 1'b0};
      8'd21: f = '{bytes: BYTES_W'(16), edge4: 1'b1, depth: 1'b0};
      default: f = '{bytes: BYTES_W'(0), edge4: 1'b0, depth: 1'b0};
    endcase
    return f;
  endfunction

endpackage

FILE: hw/rtl/tmcs_front.sv
// Front end: takes descriptors, classifies the format and forms depth times layers.
module tmcs_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  output logic                              full,
  input  logic [tmcs_pkg::CODE_W-1:0]       in_format_code,
  input  logic [tmcs_pkg::DIM_BITS-1:0]     in_base_width,
  input  logic [tmcs_pkg::DIM_BITS-1:0]     in_base_height,
  input  logic [tmcs_pkg::LAYER_BITS-1:0]   in_depth_slices,
  input  logic [tmcs_pkg::LAYER_BITS-1:0]   in_array_layers,
  input  logic [tmcs_pkg::MIP_W-1:0]        in_mip_count,
  output logic                              q_push,
  output tmcs_pkg::tmcs_item_t              q_item,
  input  tmcs_pkg::q_stat_t                 q_stat
);
  import tmcs_pkg::*;

  logic                  s1_valid_r;
  logic                  s1_valid_nxt;
  logic [DIM_BITS-1:0]   s1_w_r;
  logic [DIM_BITS-1:0]   s1_h_r;
  logic [LAYER_BITS-1:0] s1_d_r;
  logic [LAYER_BITS-1:0] s1_l_r;
  logic [MIP_W-1:0]      s1_mips_r;
  fmt_info_t             s1_fmt_r;
  logic                  s1_known_r;
  logic                  in_take;
  logic                  code_known;

  // classification of the incoming code
  assign code_known = (32'(in_format_code) < FORMAT_COUNT);
  assign in_take    = push && !full;
  assign full       = s1_valid_r && q_stat.full;
  assign q_push     = s1_valid_r && !q_stat.full;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (q_push) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // descriptor stage
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_w_r     <= in_base_width;
      s1_h_r     <= in_base_height;
      s1_d_r     <= in_depth_slices;
      s1_l_r     <= in_array_layers;
      s1_mips_r  <= in_mip_count;
      s1_known_r <= code_known;
      s1_fmt_r   <= fmt_lookup(code_known ? in_format_code : CODE_W'(0));
    end
  end

  // queue entry; the depth by layers product is registered in the queue
  always_comb begin
    q_item.width  = s1_w_r;
    q_item.height = s1_h_r;
    q_item.mips   = s1_mips_r;
    q_item.fmt    = s1_fmt_r;
    q_item.known  = s1_known_r;
    q_item.dl     = s1_d_r * s1_l_r;
  end

endmodule

FILE: hw/rtl/tmcs_queue.sv
// Two-entry queue of classified descriptors between front and back.
module tmcs_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_push,
  input  tmcs_pkg::tmcs_item_t q_item,
  input  logic                 q_pop,
  output tmcs_pkg::tmcs_item_t q_head,
  output tmcs_pkg::q_stat_t    q_stat
);
  import tmcs_pkg::*;

  tmcs_item_t  entry_r [2];
  logic        wr_ptr_r;
  logic        wr_ptr_nxt;
  logic        rd_ptr_r;
  logic        rd_ptr_nxt;
  logic [1:0]  count_r;
  logic [1:0]  count_nxt;
  logic        do_push;
  logic        do_pop;

  assign q_stat.full  = (count_r == 2'd2);
  assign q_stat.empty = (count_r == 2'd0);
  assign do_push      = q_push && !q_stat.full;
  assign do_pop       = q_pop && !q_stat.empty;
  assign q_head       = entry_r[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= q_item;
    end
  end

endmodule

FILE: hw/rtl/tmcs_back.sv
// Back end: walks the mip levels, sums block counts, scales and holds the result.
module tmcs_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tmcs_pkg::tmcs_item_t           q_head,
  input  tmcs_pkg::q_stat_t              q_stat,
  output logic                           q_pop,
  output logic                           empty,
  input  logic                           pop,
  output logic [tmcs_pkg::TOTAL_W-1:0]   out_total_bytes,
  output logic                           out_is_depth,
  output logic                           out_format_known
);
  import tmcs_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_LEVEL  = 5'b00010,
    ST_MUL_LO = 5'b00100,
    ST_MUL_HI = 5'b01000,
    ST_DONE   = 5'b10000
  } back_state_t;

  back_state_t           state_r;
  back_state_t           state_nxt;
  logic [DIM_BITS-1:0]   cur_w_r;
  logic [DIM_BITS-1:0]   cur_h_r;
  logic [MIP_W-1:0]      lvl_left_r;
  logic                  edge4_r;
  logic [BDL_W-1:0]      bdl_r;
  logic [ACC_W-1:0]      acc_r;
  logic [2*DIM_BITS-1:0] prod_r;
  logic                  prod_v_r;
  logic [TOTAL_W-1:0]    tot_r;
  logic                  depth_r;
  logic                  known_r;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic [TOTAL_W-1:0]    out_total_r;
  logic                  out_depth_r;
  logic                  out_known_r;

  logic [DIM_BITS-1:0]       sw;
  logic [DIM_BITS-1:0]       sh;
  logic [DIM_BITS:0]         sw_up;
  logic [DIM_BITS:0]         sh_up;
  logic [DIM_BITS-1:0]       bx;
  logic [DIM_BITS-1:0]       by;
  logic [2*DIM_BITS-1:0]     blk_prod;
  logic [LO_W+BDL_W-1:0]     lo_prod;
  logic [HI_W+BDL_W-1:0]     hi_prod;
  logic [HI_W+BDL_W+LO_W-1:0] hi_shift;
  logic                      out_free;

  // level size clamped to one texel, then rounded up to whole blocks
  always_comb begin
    sw       = (cur_w_r == '0) ? DIM_BITS'(1) : cur_w_r;
    sh       = (cur_h_r == '0) ? DIM_BITS'(1) : cur_h_r;
    sw_up    = {1'b0, sw} + (DIM_BITS+1)'(3);
    sh_up    = {1'b0, sh} + (DIM_BITS+1)'(3);
    bx       = edge4_r ? DIM_BITS'(sw_up >> 2) : sw;
    by       = edge4_r ? DIM_BITS'(sh_up >> 2) : sh;
    blk_prod = bx * by;
    lo_prod  = acc_r[LO_W-1:0] * bdl_r;
    hi_prod  = acc_r[ACC_W-1:LO_W] * bdl_r;
    hi_shift = {hi_prod, LO_W'(0)};
  end

  assign out_free = !out_valid_r || pop;
  assign q_pop    = (state_r == ST_IDLE) && !q_stat.empty;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (!q_stat.empty) state_nxt = ST_LEVEL;
      ST_LEVEL:  if (lvl_left_r == '0) state_nxt = ST_MUL_LO;
      ST_MUL_LO: state_nxt = ST_MUL_HI;
      ST_MUL_HI: state_nxt = ST_DONE;
      ST_DONE:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if ((state_r == ST_DONE) && out_free) begin
      out_valid_nxt = 1'b1;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      prod_v_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == ST_LEVEL) begin
        prod_v_r <= (lvl_left_r != '0);
      end else begin
        prod_v_r <= 1'b0;
      end
    end
  end

  // datapath: load, per-level products and sum, split final scale
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          cur_w_r    <= q_head.width;
          cur_h_r    <= q_head.height;
          lvl_left_r <= q_head.mips;
          edge4_r    <= q_head.fmt.edge4;
          depth_r    <= q_head.fmt.depth;
          known_r    <= q_head.known;
          bdl_r      <= q_head.fmt.bytes * q_head.dl;
          acc_r      <= '0;
        end
      end
      ST_LEVEL: begin
        acc_r <= acc_r + (prod_v_r ? ACC_W'(prod_r) : ACC_W'(0));
        if (lvl_left_r != '0) begin
          prod_r     <= blk_prod;
          cur_w_r    <= cur_w_r >> 1;
          cur_h_r    <= cur_h_r >> 1;
          lvl_left_r <= lvl_left_r - MIP_W'(1);
        end
      end
      ST_MUL_LO: tot_r <= TOTAL_W'(lo_prod);
      ST_MUL_HI: tot_r <= tot_r + TOTAL_W'(hi_shift);
      ST_DONE: begin
        if (out_free) begin
          out_total_r <= tot_r;
          out_depth_r <= depth_r;
          out_known_r <= known_r;
        end
      end
      default: ;
    endcase
  end

  assign empty            = !out_valid_r;
  assign out_total_bytes  = out_total_r;
  assign out_is_depth     = out_depth_r;
  assign out_format_known = out_known_r;

endmodule

FILE: hw/rtl/texture_mip_chain_size_unit.sv
// Top level of the texture mip chain size unit.
// Takes one texture descriptor per request and returns the byte size of its whole mip chain,
// the depth flag of its format and whether the format code is in the table. The front end
// registers and classifies a descriptor and hands it through a two-entry queue to the back
// end, so new requests are taken while one is being sized. For each request the back end
// loads it, walks the mip levels one at a time through a single block-count multiplier,
// adds the last level, makes the final scale by bytes, depth and layers (split into two
// half-width products, low then high), and hands the result to the output register once
// that is free. The sustained rate is set by that back end loop.
module texture_mip_chain_size_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            full,
  input  logic [tmcs_pkg::CODE_W-1:0]     in_format_code,
  input  logic [tmcs_pkg::DIM_BITS-1:0]   in_base_width,
  input  logic [tmcs_pkg::DIM_BITS-1:0]   in_base_height,
  input  logic [tmcs_pkg::LAYER_BITS-1:0] in_depth_slices,
  input  logic [tmcs_pkg::LAYER_BITS-1:0] in_array_layers,
  input  logic [tmcs_pkg::MIP_W-1:0]      in_mip_count,
  output logic                            empty,
  input  logic                            pop,
  output logic [tmcs_pkg::TOTAL_W-1:0]    out_total_bytes,
  output logic                            out_is_depth,
  output logic                            out_format_known
);
  import tmcs_pkg::*;

  logic       q_push;
  logic       q_pop;
  tmcs_item_t q_item;
  tmcs_item_t q_head;
  q_stat_t    q_stat;

  tmcs_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_format_code  (in_format_code),
    .in_base_width   (in_base_width),
    .in_base_height  (in_base_height),
    .in_depth_slices (in_depth_slices),
    .in_array_layers (in_array_layers),
    .in_mip_count    (in_mip_count),
    .q_push          (q_push),
    .q_item          (q_item),
    .q_stat          (q_stat)
  );

  tmcs_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .q_item (q_item),
    .q_pop  (q_pop),
    .q_head (q_head),
    .q_stat (q_stat)
  );

  tmcs_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_head           (q_head),
    .q_stat           (q_stat),
    .q_pop            (q_pop),
    .empty            (empty),
    .pop              (pop),
    .out_total_bytes  (out_total_bytes),
    .out_is_depth     (out_is_depth),
    .out_format_known (out_format_known)
  );

  // front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("front pushed into a full queue");

  // back only takes from a queue that holds something
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("back popped an empty queue");

  // a code past the table gives a zero, non-depth result
  a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_format_known) |-> (out_total_bytes == '0) && !out_is_depth)
    else $error("unknown format gave a nonzero result");

  // the front stalls a request only while the queue is full
  a_full_cause: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> q_stat.full)
    else $error("request stalled with room in the queue");

endmodule

FILE: sim/texture_mip_chain_size_unit_test.sv
// Self-checking testbench for the texture mip chain size unit.
`timescale 1ns / 100ps

module texture_mip_chain_size_unit_test;
  import tmcs_pkg::*;

  // One texture descriptor; drain makes the sender wait until all results are back
  typedef struct {
    bit [CODE_W-1:0]     code;
    bit [DIM_BITS-1:0]   width;
    bit [DIM_BITS-1:0]   height;
    bit [LAYER_BITS-1:0] depth;
    bit [LAYER_BITS-1:0] layers;
    bit [MIP_W-1:0]      mips;
    bit                  drain;
  } desc_t;

  typedef struct {
    bit [TOTAL_W-1:0] total;
    bit               is_depth;
    bit               known;
  } chain_size_t;

  // Bytes per block, indexed by format code
  localparam int unsigned FMT_BYTES [FORMAT_COUNT] = '{
    0, 1, 2, 4, 4, 4, 2, 4, 8, 4, 8, 16, 4, 4, 12, 2, 4, 4, 8, 16, 16, 16
  };
  localparam int FIRST_DEPTH_FMT = 15;
  localparam int LAST_DEPTH_FMT  = 17;
  localparam int FIRST_BC_FMT    = 18;
  localparam int RANDOM_ITEMS    = 1200;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  push = 1'b0;
  logic                  full;
  logic [CODE_W-1:0]     in_format_code = '0;
  logic [DIM_BITS-1:0]   in_base_width = '0;
  logic [DIM_BITS-1:0]   in_base_height = '0;
  logic [LAYER_BITS-1:0] in_depth_slices = '0;
  logic [LAYER_BITS-1:0] in_array_layers = '0;
  logic [MIP_W-1:0]      in_mip_count = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic [TOTAL_W-1:0]    out_total_bytes;
  logic                  out_is_depth;
  logic                  out_format_known;

  desc_t       pending_descs[$];
  chain_size_t expected_sizes[$];
  desc_t       cur_desc;
  chain_size_t want;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned sent_cnt;
  int unsigned got_cnt;
  int unsigned errors;

  texture_mip_chain_size_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_format_code   (in_format_code),
    .in_base_width    (in_base_width),
    .in_base_height   (in_base_height),
    .in_depth_slices  (in_depth_slices),
    .in_array_layers  (in_array_layers),
    .in_mip_count     (in_mip_count),
    .empty            (empty),
    .pop              (pop),
    .out_total_bytes  (out_total_bytes),
    .out_is_depth     (out_is_depth),
    .out_format_known (out_format_known)
  );

  always #2 clk = ~clk;

  // Byte size of the whole mip chain of one descriptor
  function automatic chain_size_t chain_size_of(input desc_t d);
    chain_size_t res;
    bit [63:0]   blk;
    bit [63:0]   bpb;
    bit [63:0]   wl;
    bit [63:0]   hl;
    bit [63:0]   acc;
    int          fmt;
    res.known = (d.code < FORMAT_COUNT);
    fmt = res.known ? int'(d.code) : 0;
    bpb = 64'(FMT_BYTES[fmt]);
    blk = (fmt >= FIRST_BC_FMT) ? 64'd4 : 64'd1;
    res.is_depth = (fmt >= FIRST_DEPTH_FMT && fmt <= LAST_DEPTH_FMT);
    acc = '0;
    for (int lvl = 0; lvl < int'(d.mips); lvl++) begin
      wl = 64'(d.width) >> lvl;
      hl = 64'(d.height) >> lvl;
      if (wl == 64'd0) wl = 64'd1;
      if (hl == 64'd0) hl = 64'd1;
      wl = (wl + blk - 64'd1) / blk;
      hl = (hl + blk - 64'd1) / blk;
      // Products stay below 2^64; keep the running sum to the result width
      acc = (acc + wl * hl * bpb * 64'(d.depth) * 64'(d.layers)) & ((64'd1 << TOTAL_W) - 64'd1);
    end
    res.total = acc[TOTAL_W-1:0];
    return res;
  endfunction

  function automatic desc_t mk_desc(input int code, input int w, input int h,
                                    input int dep, input int lay, input int mips);
    desc_t d;
    d.code   = CODE_W'(code);
    d.width  = DIM_BITS'(w);
    d.height = DIM_BITS'(h);
    d.depth  = LAYER_BITS'(dep);
    d.layers = LAYER_BITS'(lay);
    d.mips   = MIP_W'(mips);
    d.drain  = 1'b0;
    return d;
  endfunction

  // Mostly small dimensions, some full range, powers of two and near-max values
  function automatic int rand_dim();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return $urandom_range(0, 64);
    if (r < 8) return $urandom_range(0, 65535);
    if (r == 8) return 1 << $urandom_range(0, 15);
    return 65535 - $urandom_range(0, 3);
  endfunction

  // Depth and layer counts, now and then past the nominal range to reach wrap-around
  function automatic int rand_count();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(0, 8);
    if (r < 9) return $urandom_range(0, 2048);
    return $urandom_range(0, 4095);
  endfunction

  function automatic desc_t rand_desc();
    int code;
    code = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                        : $urandom_range(0, FORMAT_COUNT - 1);
    return mk_desc(code, rand_dim(), rand_dim(), rand_count(), rand_count(),
                   $urandom_range(0, 31));
  endfunction

  // Idle length: mostly none or short, a few long; none inside calm windows
  function automatic int unsigned pick_idle(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Sender: presents queued requests, logs a prediction for each accepted one
  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
      gap_left = pick_idle(1'b0);
    end else if (!(push && full)) begin
      if (push) begin
        expected_sizes.push_back(chain_size_of(cur_desc));
        sent_cnt++;
        gap_left = pick_idle(sent_cnt >= 600 && sent_cnt < 750);
      end
      if (gap_left > 0) begin
        gap_left--;
        push <= 1'b0;
      end else if (pending_descs.size() > 0 &&
                   !(pending_descs[0].drain && expected_sizes.size() > 0)) begin
        cur_desc = pending_descs.pop_front();
        in_format_code  <= cur_desc.code;
        in_base_width   <= cur_desc.width;
        in_base_height  <= cur_desc.height;
        in_depth_slices <= cur_desc.depth;
        in_array_layers <= cur_desc.layers;
        in_mip_count    <= cur_desc.mips;
        push <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Receiver: checks each popped result against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
      stall_left = 0;
    end else begin
      if (pop && !empty) begin
        if (expected_sizes.size() == 0) begin
          errors++;
          $display("%0t: result with no request waiting, total %0d", $time, out_total_bytes);
        end else begin
          want = expected_sizes.pop_front();
          if (out_total_bytes !== want.total) begin
            errors++;
            $display("%0t: total_bytes expected %0d, actual %0d",
                     $time, want.total, out_total_bytes);
          end
          if (out_is_depth !== want.is_depth) begin
            errors++;
            $display("%0t: is_depth expected %0d, actual %0d",
                     $time, want.is_depth, out_is_depth);
          end
          if (out_format_known !== want.known) begin
            errors++;
            $display("%0t: format_known expected %0d, actual %0d",
                     $time, want.known, out_format_known);
          end
        end
        got_cnt++;
        // One long hold-off so the block backs up and stalls its input
        stall_left = (got_cnt == 300) ? 400 : pick_idle(got_cnt >= 600 && got_cnt < 750);
      end
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    desc_t d;
    // unknown entry, codes past the table
    pending_descs.push_back(mk_desc(0, 16, 16, 1, 1, 5));
    pending_descs.push_back(mk_desc(FORMAT_COUNT, 64, 64, 1, 1, 7));
    pending_descs.push_back(mk_desc(255, 65535, 65535, 2048, 2048, 31));
    // plain, depth and block formats
    pending_descs.push_back(mk_desc(1, 1, 1, 1, 1, 1));
    pending_descs.push_back(mk_desc(14, 100, 37, 3, 2, 8));
    pending_descs.push_back(mk_desc(15, 640, 480, 1, 6, 10));
    pending_descs.push_back(mk_desc(17, 33, 65535, 1, 1, 17));
    pending_descs.push_back(mk_desc(18, 5, 3, 1, 1, 4));
    pending_descs.push_back(mk_desc(21, 4097, 4095, 2, 3, 13));
    // zero dimensions clamp to one texel
    pending_descs.push_back(mk_desc(11, 0, 0, 1, 1, 31));
    pending_descs.push_back(mk_desc(20, 0, 65535, 1, 1, 31));
    // zero depth, zero layers, zero levels
    pending_descs.push_back(mk_desc(8, 256, 256, 0, 4, 9));
    pending_descs.push_back(mk_desc(8, 256, 256, 4, 0, 9));
    pending_descs.push_back(mk_desc(19, 256, 256, 4, 4, 0));
    // largest in-range total and wrap-around beyond it
    pending_descs.push_back(mk_desc(19, 65535, 65535, 2048, 2048, 31));
    pending_descs.push_back(mk_desc(19, 65535, 65535, 4095, 4095, 31));
    pending_descs.push_back(mk_desc(11, 65535, 65535, 4095, 4095, 31));
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      d = rand_desc();
      // sender pauses until the block has drained
      d.drain = (i == 0 || i == 900);
      pending_descs.push_back(d);
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (!(pending_descs.size() == 0 && !push && expected_sizes.size() == 0));
    repeat (60) @(posedge clk);

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
